@@ design/fit_pkg.sv @@
// shared types and constants for the frame interval timer
package fit_pkg;

    // timestamp and interval width in counter ticks
    localparam int STAMP_BITS = 48;
    // width of the frame counter and latched frame rate
    localparam int RATE_BITS  = 16;
    // width of the ticks-per-second register
    localparam int TPS_BITS   = 32;
    // reset value of the ticks-per-second register
    localparam logic [TPS_BITS-1:0] TPS_RESET = 32'd10000000;
    // per-second accumulator holds at most one second plus one interval
    localparam int SACC_BITS  = STAMP_BITS + 1;

    // event kinds carried in the input tuser
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

endpackage

@@ design/frame_interval_timer.sv @@
// frame interval timer: moving average of frame intervals, frame rate, run time
// Input events come in on the s-side stream: tuser carries the event kind
// (tick, start, stop, reset) and tdata the 48-bit free-running counter value.
// Every event gives exactly one result on the m-side stream: the average frame
// interval, the frame rate latched each second and the running time without
// paused spans in tdata, and the stopped flag in tuser.
// The block works on one event at a time. A tick while running passes through
// the restoring divider, one quotient bit per cycle, for window sum over count,
// unless the window is empty. The interval window sits in a single-port
// synchronous ring memory, read at accept and written back later in the same
// event. Start, stop, reset and a tick while stopped skip the window steps.
// The next event is taken while the previous result still waits in the output
// register; if the receiver stalls, the block waits before its last step and
// holds tready low until the output register frees.
// Reset (synchronous, active low) clears all timing state and sets
// ticks_per_second to 10000000; the ring memory needs no clearing because an
// entry is only read back once the window has filled. The user writes the
// ticks_per_second register on the cfg channel, which is always ready, only
// while idle; the block itself does not enforce this.
module frame_interval_timer
    import fit_pkg::*;
#(
    parameter int WINDOW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write: ticks_per_second
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [TPS_BITS-1:0]   i_cfg_data,
    // event input
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [47:0]           i_s_tdata,   // timestamp
    input  logic [1:0]            i_s_tuser,   // cmd
    // result output
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [111:0]          o_m_tdata,   // avg_frame_ticks, frame_rate, total_ticks
    output logic [0:0]            o_m_tuser    // is_stopped
);

    localparam int IDX_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_BITS = $clog2(WINDOW + 1);
    localparam int SUM_BITS = STAMP_BITS + CNT_BITS;
    localparam int DIV_BITS = $clog2(SUM_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_START,
        S_TEST,
        S_CHECK,
        S_PUSH,
        S_ADD,
        S_DIV,
        S_TOT,
        S_OUT
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [STAMP_BITS-1:0]   r_ts;
    logic [TPS_BITS-1:0]     r_tps;

    // timing state
    logic [IDX_BITS-1:0]     r_head;
    logic [CNT_BITS-1:0]     r_count;
    logic [SUM_BITS-1:0]     r_sum;
    logic [STAMP_BITS-1:0]   r_avg;
    logic [STAMP_BITS-1:0]   r_prev;
    logic [STAMP_BITS-1:0]   r_latest;
    logic [STAMP_BITS-1:0]   r_origin;
    logic [STAMP_BITS-1:0]   r_halt;
    logic [STAMP_BITS-1:0]   r_paused;
    logic                    r_halted;
    logic [RATE_BITS-1:0]    r_frames;
    logic [SACC_BITS-1:0]    r_sacc;
    logic [RATE_BITS-1:0]    r_rate;

    // per-event working registers
    logic [STAMP_BITS-1:0]   r_iv;
    logic [STAMP_BITS-1:0]   r_diff;
    logic                    r_push;
    logic [SUM_BITS-1:0]     r_dq;
    logic [CNT_BITS-1:0]     r_rem;
    logic [DIV_BITS-1:0]     r_kcnt;

    // output register
    logic                    r_ovalid;
    logic [111:0]            r_odata;
    logic                    r_ostop;

    // ring memory
    logic [STAMP_BITS-1:0]   r_ring [WINDOW];
    logic [STAMP_BITS-1:0]   r_rd;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_out_free;
    logic [CNT_BITS:0]       w_rem_sh;
    logic                    w_qbit;
    logic [CNT_BITS:0]       w_rem_sub;
    logic [SUM_BITS-1:0]     n_sum;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_full      = (r_count == CNT_BITS'(WINDOW));
    assign w_out_free  = !r_ovalid || i_m_tready;

    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ostop;

    // one restoring division step
    assign w_rem_sh  = {r_rem, r_dq[SUM_BITS-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_count});
    assign w_rem_sub = w_rem_sh - {1'b0, r_count};

    // window sum after the new interval goes in
    assign n_sum = r_sum + SUM_BITS'(r_iv);

    // ring memory: read at accept, write back on push
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && r_push) begin
            r_ring[r_head] <= r_iv;
        end
        if (w_accept) begin
            r_rd <= r_ring[r_head];
        end
    end

    // sequencer with timing state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tps    <= TPS_RESET;
            r_head   <= '0;
            r_count  <= '0;
            r_sum    <= '0;
            r_avg    <= '0;
            r_prev   <= '0;
            r_latest <= '0;
            r_origin <= '0;
            r_halt   <= '0;
            r_paused <= '0;
            r_halted <= 1'b0;
            r_frames <= '0;
            r_sacc   <= '0;
            r_rate   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // config transfer
            if (i_cfg_valid) begin
                r_tps <= i_cfg_data;
            end

            // output transfer frees the register, unless a new result loads it
            if (r_ovalid && i_m_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= t_cmd'(i_s_tuser);
                        r_ts    <= i_s_tdata[STAMP_BITS-1:0];
                        r_state <= S_EXEC;
                    end
                end

                // decode the event
                S_EXEC: begin
                    unique case (r_cmd)
                        CMD_TICK: begin
                            if (r_halted) begin
                                r_avg   <= '0;
                                r_state <= S_TOT;
                            end else begin
                                r_iv     <= r_ts - r_prev;
                                r_prev   <= r_ts;
                                r_latest <= r_ts;
                                if (r_frames != {RATE_BITS{1'b1}}) begin
                                    r_frames <= r_frames + 1'b1;
                                end
                                r_state  <= S_TEST;
                            end
                        end
                        CMD_START: begin
                            if (r_halted) begin
                                r_diff  <= r_ts - r_halt;
                                r_prev  <= r_ts;
                                r_halt  <= '0;
                                r_halted <= 1'b0;
                                r_state <= S_START;
                            end else begin
                                r_state <= S_TOT;
                            end
                        end
                        CMD_STOP: begin
                            if (!r_halted) begin
                                r_halt   <= r_ts;
                                r_halted <= 1'b1;
                            end
                            r_state <= S_TOT;
                        end
                        CMD_RESET: begin
                            r_origin <= r_ts;
                            r_prev   <= r_ts;
                            r_latest <= r_ts;
                            r_halt   <= '0;
                            r_paused <= '0;
                            r_halted <= 1'b0;
                            r_state  <= S_TOT;
                        end
                        default: begin
                            r_state <= S_TOT;
                        end
                    endcase
                end

                // accumulate paused span
                S_START: begin
                    r_paused <= r_paused + r_diff;
                    r_state  <= S_TOT;
                end

                // distance from the average, per-second accumulation
                S_TEST: begin
                    r_diff  <= (r_iv >= r_avg) ? (r_iv - r_avg) : (r_avg - r_iv);
                    r_sacc  <= r_sacc + SACC_BITS'(r_iv);
                    r_state <= S_CHECK;
                end

                // outlier test and frame-rate latch
                S_CHECK: begin
                    r_push <= (r_diff < STAMP_BITS'(r_tps));
                    if (r_sacc > SACC_BITS'(r_tps)) begin
                        r_rate   <= r_frames;
                        r_frames <= '0;
                        r_sacc   <= '0;
                    end
                    r_state <= S_PUSH;
                end

                // replace the oldest entry or grow the window
                S_PUSH: begin
                    if (r_push) begin
                        if (w_full) begin
                            r_sum <= r_sum - SUM_BITS'(r_rd);
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                        if (r_head == IDX_BITS'(WINDOW - 1)) begin
                            r_head <= '0;
                        end else begin
                            r_head <= r_head + 1'b1;
                        end
                    end
                    r_state <= S_ADD;
                end

                // add the new interval if kept, and start the divider unless the window is empty
                S_ADD: begin
                    if (r_push) begin
                        r_sum <= n_sum;
                    end
                    r_dq   <= r_push ? n_sum : r_sum;
                    r_rem  <= '0;
                    r_kcnt <= DIV_BITS'(SUM_BITS);
                    if (r_count == '0) begin
                        r_avg   <= '0;
                        r_state <= S_TOT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end

                // one quotient bit per cycle
                S_DIV: begin
                    if (r_kcnt == '0) begin
                        r_avg   <= r_dq[STAMP_BITS-1:0];
                        r_state <= S_TOT;
                    end else begin
                        r_rem  <= w_qbit ? w_rem_sub[CNT_BITS-1:0]
                                         : w_rem_sh[CNT_BITS-1:0];
                        r_dq   <= {r_dq[SUM_BITS-2:0], w_qbit};
                        r_kcnt <= r_kcnt - 1'b1;
                    end
                end

                // running time, first half
                S_TOT: begin
                    r_diff  <= (r_halted ? r_halt : r_latest) - r_paused;
                    r_state <= S_OUT;
                end

                // load the result once the output register is free
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {r_diff - r_origin, r_rate,
                                     r_halted ? {STAMP_BITS{1'b0}} : r_avg};
                        r_ostop  <= r_halted;
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // window never holds more samples than entries
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(WINDOW))
        else $error("sample count above window depth");

    // ring head stays inside the memory
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= IDX_BITS'(WINDOW - 1))
        else $error("ring head out of range");

    // an accepted event starts work at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted event not started");

    // a stopped result reports a zero average
    a_stop_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[47:0] == 48'd0)
        else $error("nonzero average while stopped");
`endif

endmodule
